>>> rtl/fsched_pkg.sv
// ----------------------------------------------------------------------------
// fsched_pkg
// Shared types and constants of the first-come-first-served schedule block:
// field widths of the stream words, default sizes and sequencer states.
// ----------------------------------------------------------------------------
package fsched_pkg;

   // default sizes
   localparam int DEFAULT_MAX_JOBS  = 32;
   localparam int DEFAULT_TIME_BITS = 16;

   // request word fields
   localparam int ARRIVAL_W  = 16;
   localparam int BURST_W    = 16;
   localparam int REQ_DATA_W = ARRIVAL_W + BURST_W;

   // response word fields
   localparam int ID_W     = 6;
   localparam int ARR_O_W  = 16;
   localparam int BUR_O_W  = 16;
   localparam int COMPL_W  = 22;
   localparam int TURN_W   = 21;
   localparam int WAIT_W   = 21;
   localparam int TTURN_W  = 26;
   localparam int TWAIT_W  = 26;
   localparam int COUNT_W  = 6;
   localparam int RSP_DATA_W = ID_W + ARR_O_W + BUR_O_W + COMPL_W + TURN_W + WAIT_W
                             + TTURN_W + TWAIT_W + COUNT_W;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_CMP,
      ST_PLACE,
      ST_EMIT_RD,
      ST_START,
      ST_COMP,
      ST_WAIT,
      ST_TAT,
      ST_TSUM,
      ST_WSUM,
      ST_SEND
   } sched_state_type;

endpackage

>>> rtl/fcfs_schedule_times.sv
// ----------------------------------------------------------------------------
// fcfs_schedule_times
// First-come-first-served schedule: loads a set of jobs, keeps them sorted
// by arrival (ties in load order) and emits one timing word per job.
// ----------------------------------------------------------------------------
// Usage
// req channel: one word per job, tdata = {burst, arrival}, tlast closes the
// set. Ids 1..n follow load order. Jobs beyond MAX_JOBS are dropped, but
// their tlast still closes the set.
// rsp channel: one word per job in arrival order; tlast marks the final
// word, which also carries the turnaround and waiting totals.
// Operation
// Before the next job word is taken, each already loaded job with a later
// arrival is moved one slot up through the job memory, one read and one
// compare per move. One more read and compare stop the move when fewer
// than all of the held jobs arrive later. A dropped word without tlast is
// accepted and leaves the sequencer idle. Each result then takes one
// memory read and the shared adder for start, completion, waiting,
// turnaround and the two totals, then waits in the send state until
// rsp_tready is seen.
// The block takes no request while results are in flight; a stalled
// receiver holds the result word stable and simply freezes the sequencer.
// Reset returns the sequencer to idle with an empty job set; the job memory
// is not cleared, only entries of the current set are ever read.
// ----------------------------------------------------------------------------
module fcfs_schedule_times #(
   parameter int MAX_JOBS  = fsched_pkg::DEFAULT_MAX_JOBS,
   parameter int TIME_BITS = fsched_pkg::DEFAULT_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fsched_pkg::REQ_DATA_W-1:0] req_tdata,  // arrival_time, burst_time
   input  logic                              req_tlast,  // last_item
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // process_id, arrival_out, burst_out, completion_time, turnaround_time,
   // waiting_time, total_turnaround, total_waiting, job_count
   output logic [fsched_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast   // last_result
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int CT_W  = TIME_BITS + CNT_W;
   localparam int SUM_W = CT_W + CNT_W;
   localparam int AW    = SUM_W;
   localparam int XW    = SUM_W + 32;

   fsched_pkg::sched_state_type state_ff, state_in;

   // control registers
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] k_ff;

   // incoming job
   logic [TIME_BITS-1:0] new_arr_ff;
   logic [TIME_BITS-1:0] new_bur_ff;
   logic [CNT_W-1:0]     new_id_ff;
   logic                 last_ff;

   // job memory
   logic [TIME_BITS-1:0] arr_mem [MAX_JOBS];
   logic [TIME_BITS-1:0] bur_mem [MAX_JOBS];
   logic [CNT_W-1:0]     id_mem  [MAX_JOBS];
   logic [TIME_BITS-1:0] rd_arr_ff;
   logic [TIME_BITS-1:0] rd_bur_ff;
   logic [CNT_W-1:0]     rd_id_ff;

   // schedule registers
   logic [CT_W-1:0]  run_ff;
   logic [CT_W-1:0]  start_ff;
   logic [CT_W-1:0]  wt_ff;
   logic [CT_W-1:0]  tat_ff;
   logic [SUM_W-1:0] tsum_ff;
   logic [SUM_W-1:0] wsum_ff;

   // datapath control
   logic             req_acc;
   logic             full;
   logic             fin;
   logic             mem_we;
   logic             mem_wsel_new;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [AW-1:0]    alu_x;
   logic [AW-1:0]    alu_y;
   logic             alu_sub;
   logic [AW:0]      alu_full;
   logic [AW-1:0]    alu_res;
   logic             alu_borrow;

   // input field extraction, masked to TIME_BITS
   logic [XW-1:0] in_arr_x;
   logic [XW-1:0] in_bur_x;

   assign in_arr_x = XW'(req_tdata[fsched_pkg::ARRIVAL_W-1:0]);
   assign in_bur_x = XW'(req_tdata[fsched_pkg::REQ_DATA_W-1:fsched_pkg::ARRIVAL_W]);

   assign req_acc = req_tvalid && req_tready;
   assign full    = (count_ff == CNT_W'(MAX_JOBS));
   assign fin     = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);

   // shared adder / subtractor
   assign alu_full   = {1'b0, alu_x} + {1'b0, alu_y ^ {AW{alu_sub}}} + (AW + 1)'(alu_sub);
   assign alu_res    = alu_full[AW-1:0];
   assign alu_borrow = alu_sub & ~alu_full[AW];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsched_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (!full) begin
                  state_in = (count_ff == '0) ? fsched_pkg::ST_PLACE : fsched_pkg::ST_SHIFT_RD;
               end else if (req_tlast) begin
                  state_in = fsched_pkg::ST_EMIT_RD;
               end
            end
         end
         fsched_pkg::ST_SHIFT_RD:  state_in = fsched_pkg::ST_SHIFT_CMP;
         fsched_pkg::ST_SHIFT_CMP: begin
            if (alu_borrow && (j_ff != IDX_W'(1))) begin
               state_in = fsched_pkg::ST_SHIFT_RD;
            end else begin
               state_in = fsched_pkg::ST_PLACE;
            end
         end
         fsched_pkg::ST_PLACE: begin
            state_in = last_ff ? fsched_pkg::ST_EMIT_RD : fsched_pkg::ST_IDLE;
         end
         fsched_pkg::ST_EMIT_RD: state_in = fsched_pkg::ST_START;
         fsched_pkg::ST_START:   state_in = fsched_pkg::ST_COMP;
         fsched_pkg::ST_COMP:    state_in = fsched_pkg::ST_WAIT;
         fsched_pkg::ST_WAIT:    state_in = fsched_pkg::ST_TAT;
         fsched_pkg::ST_TAT:     state_in = fsched_pkg::ST_TSUM;
         fsched_pkg::ST_TSUM:    state_in = fsched_pkg::ST_WSUM;
         fsched_pkg::ST_WSUM:    state_in = fsched_pkg::ST_SEND;
         fsched_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = fin ? fsched_pkg::ST_IDLE : fsched_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = fsched_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshakes, memory port and adder operands
   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      mem_we       = 1'b0;
      mem_wsel_new = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = k_ff;
      alu_x        = '0;
      alu_y        = '0;
      alu_sub      = 1'b0;
      case (state_ff)
         fsched_pkg::ST_IDLE: req_tready = 1'b1;
         fsched_pkg::ST_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_ff - IDX_W'(1);
         end
         fsched_pkg::ST_SHIFT_CMP: begin
            // new arrival below the stored one: move stored job up a slot
            alu_x   = AW'(new_arr_ff);
            alu_y   = AW'(rd_arr_ff);
            alu_sub = 1'b1;
            mem_we  = alu_borrow;
         end
         fsched_pkg::ST_PLACE: begin
            mem_we       = 1'b1;
            mem_wsel_new = 1'b1;
         end
         fsched_pkg::ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
         end
         fsched_pkg::ST_START: begin
            alu_x   = AW'(run_ff);
            alu_y   = AW'(rd_arr_ff);
            alu_sub = 1'b1;
         end
         fsched_pkg::ST_COMP: begin
            alu_x = AW'(start_ff);
            alu_y = AW'(rd_bur_ff);
         end
         fsched_pkg::ST_WAIT: begin
            alu_x   = AW'(start_ff);
            alu_y   = AW'(rd_arr_ff);
            alu_sub = 1'b1;
         end
         fsched_pkg::ST_TAT: begin
            alu_x = AW'(wt_ff);
            alu_y = AW'(rd_bur_ff);
         end
         fsched_pkg::ST_TSUM: begin
            alu_x = tsum_ff;
            alu_y = AW'(tat_ff);
         end
         fsched_pkg::ST_WSUM: begin
            alu_x = wsum_ff;
            alu_y = AW'(wt_ff);
         end
         fsched_pkg::ST_SEND: rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsched_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fsched_pkg::ST_IDLE && req_acc && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (state_ff == fsched_pkg::ST_SEND && rsp_tready && fin) begin
            count_ff <= '0;
         end
      end
   end

   // job capture, slot and result index
   always_ff @(posedge clock) begin
      case (state_ff)
         fsched_pkg::ST_IDLE: begin
            if (req_acc) begin
               new_arr_ff <= in_arr_x[TIME_BITS-1:0];
               new_bur_ff <= in_bur_x[TIME_BITS-1:0];
               new_id_ff  <= count_ff + CNT_W'(1);
               last_ff    <= req_tlast;
               j_ff       <= count_ff[IDX_W-1:0];
               k_ff       <= '0;
               run_ff     <= '0;
               tsum_ff    <= '0;
               wsum_ff    <= '0;
            end
         end
         fsched_pkg::ST_SHIFT_CMP: begin
            if (alu_borrow) begin
               j_ff <= j_ff - IDX_W'(1);
            end
         end
         fsched_pkg::ST_START: start_ff <= alu_borrow ? CT_W'(rd_arr_ff) : run_ff;
         fsched_pkg::ST_COMP:  run_ff   <= alu_res[CT_W-1:0];
         fsched_pkg::ST_WAIT:  wt_ff    <= alu_res[CT_W-1:0];
         fsched_pkg::ST_TAT:   tat_ff   <= alu_res[CT_W-1:0];
         fsched_pkg::ST_TSUM:  tsum_ff  <= alu_res[SUM_W-1:0];
         fsched_pkg::ST_WSUM:  wsum_ff  <= alu_res[SUM_W-1:0];
         fsched_pkg::ST_SEND: begin
            if (rsp_tready) begin
               k_ff <= k_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // job memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         arr_mem[j_ff] <= mem_wsel_new ? new_arr_ff : rd_arr_ff;
         bur_mem[j_ff] <= mem_wsel_new ? new_bur_ff : rd_bur_ff;
         id_mem[j_ff]  <= mem_wsel_new ? new_id_ff  : rd_id_ff;
      end
      if (rd_en) begin
         rd_arr_ff <= arr_mem[rd_addr];
         rd_bur_ff <= bur_mem[rd_addr];
         rd_id_ff  <= id_mem[rd_addr];
      end
   end

   // response word, fields cut or padded to their port widths
   logic [XW-1:0] id_x, arr_x, bur_x, ct_x, tat_x, wt_x, ts_x, ws_x, cnt_x;

   assign id_x  = XW'(rd_id_ff);
   assign arr_x = XW'(rd_arr_ff);
   assign bur_x = XW'(rd_bur_ff);
   assign ct_x  = XW'(run_ff);
   assign tat_x = XW'(tat_ff);
   assign wt_x  = XW'(wt_ff);
   assign ts_x  = fin ? XW'(tsum_ff) : '0;
   assign ws_x  = fin ? XW'(wsum_ff) : '0;
   assign cnt_x = XW'(count_ff);

   assign rsp_tdata = {cnt_x[fsched_pkg::COUNT_W-1:0],
                       ws_x[fsched_pkg::TWAIT_W-1:0],
                       ts_x[fsched_pkg::TTURN_W-1:0],
                       wt_x[fsched_pkg::WAIT_W-1:0],
                       tat_x[fsched_pkg::TURN_W-1:0],
                       ct_x[fsched_pkg::COMPL_W-1:0],
                       bur_x[fsched_pkg::BUR_O_W-1:0],
                       arr_x[fsched_pkg::ARR_O_W-1:0],
                       id_x[fsched_pkg::ID_W-1:0]};
   assign rsp_tlast = fin;

`ifndef SYNTHESIS
   // job count never passes the memory depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_JOBS))
      else $error("job count above memory depth");

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response active together");

   // a shift always has a lower slot to read
   a_shift_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsched_pkg::ST_SHIFT_RD) |-> (j_ff != '0))
      else $error("shift from slot zero");

   // the final word empties the job set
   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0))
      else $error("job set not cleared after final word");

   // completion never precedes the start of service
   a_compl_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsched_pkg::ST_SEND) |-> (run_ff >= start_ff))
      else $error("completion before start");
`endif

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fcfs_schedule_times. Job sets are streamed in
// with bursty request timing while the receiver stalls on a pattern of its
// own. Every response word is compared field by field against a local
// first-come-first-served schedule that is worked out when each set closes.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_JOBS       = fsched_pkg::DEFAULT_MAX_JOBS;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int TARGET_WORDS   = 170;

   // response word bit positions, lowest field first
   localparam int ARR_LSB   = fsched_pkg::ID_W;
   localparam int BUR_LSB   = ARR_LSB + fsched_pkg::ARR_O_W;
   localparam int COMPL_LSB = BUR_LSB + fsched_pkg::BUR_O_W;
   localparam int TURN_LSB  = COMPL_LSB + fsched_pkg::COMPL_W;
   localparam int WAIT_LSB  = TURN_LSB + fsched_pkg::TURN_W;
   localparam int TTURN_LSB = WAIT_LSB + fsched_pkg::WAIT_W;
   localparam int TWAIT_LSB = TTURN_LSB + fsched_pkg::TTURN_W;
   localparam int COUNT_LSB = TWAIT_LSB + fsched_pkg::TWAIT_W;

   typedef enum {SET_WIDE, SET_DENSE, SET_TIES, SET_PEAK} set_style_type;
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   typedef struct {
      logic [fsched_pkg::ARRIVAL_W-1:0] arrival;
      logic [fsched_pkg::BURST_W-1:0]   burst;
      logic                             last;
      logic                             drain_first;
   } job_word_type;

   typedef struct {
      logic [fsched_pkg::ARRIVAL_W-1:0] arrival;
      logic [fsched_pkg::BURST_W-1:0]   burst;
      logic [fsched_pkg::ID_W-1:0]      id;
   } held_job_type;

   typedef struct {
      logic [fsched_pkg::ID_W-1:0]    id;
      logic [fsched_pkg::ARR_O_W-1:0] arrival;
      logic [fsched_pkg::BUR_O_W-1:0] burst;
      logic [fsched_pkg::COMPL_W-1:0] completion;
      logic [fsched_pkg::TURN_W-1:0]  turnaround;
      logic [fsched_pkg::WAIT_W-1:0]  waiting;
      logic [fsched_pkg::TTURN_W-1:0] total_turn;
      logic [fsched_pkg::TWAIT_W-1:0] total_wait;
      logic [fsched_pkg::COUNT_W-1:0] count;
      logic                           last;
   } timing_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [fsched_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // arrival_time, burst_time
   logic                              req_tlast = 1'b0; // last_item
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // process_id, arrival_out, burst_out, completion_time, turnaround_time,
   // waiting_time, total_turnaround, total_waiting, job_count
   logic [fsched_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                              rsp_tlast;        // last_result

   job_word_type   pending_words[$];
   held_job_type   held_jobs[$];
   timing_row_type expected_rows[$];
   int             rows_predicted = 0;
   int             rows_checked = 0;
   int             errors = 0;
   int             cycle_count = 0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             rx_timer = 0;
   rx_mode_type    rx_mode = RX_OPEN;

   fcfs_schedule_times dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // stable sort of the closed set by arrival, then fcfs timing per job
   task automatic schedule_jobs();
      held_job_type      sorted[$];
      held_job_type      key;
      timing_row_type    row;
      int                j;
      longint unsigned   busy_until, ct, tat, wt, tat_sum, wt_sum;
      sorted = held_jobs;
      for (int i = 1; i < sorted.size(); i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1].arrival > key.arrival) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      busy_until = 0;
      tat_sum = 0;
      wt_sum = 0;
      for (int k = 0; k < sorted.size(); k++) begin
         if (busy_until < sorted[k].arrival)
            ct = sorted[k].arrival + sorted[k].burst;
         else
            ct = busy_until + sorted[k].burst;
         busy_until = ct;
         tat = ct - sorted[k].arrival;
         wt = tat - sorted[k].burst;
         tat_sum += tat;
         wt_sum += wt;
         row.id         = sorted[k].id;
         row.arrival    = sorted[k].arrival;
         row.burst      = sorted[k].burst;
         row.completion = fsched_pkg::COMPL_W'(ct);
         row.turnaround = fsched_pkg::TURN_W'(tat);
         row.waiting    = fsched_pkg::WAIT_W'(wt);
         row.last       = (k == sorted.size() - 1);
         row.total_turn = row.last ? fsched_pkg::TTURN_W'(tat_sum) : '0;
         row.total_wait = row.last ? fsched_pkg::TWAIT_W'(wt_sum) : '0;
         row.count      = fsched_pkg::COUNT_W'(sorted.size());
         expected_rows.push_back(row);
         rows_predicted++;
      end
      held_jobs.delete();
   endtask

   task automatic add_job(int arrival, int burst, bit last, bit drain_first);
      job_word_type w;
      w.arrival     = fsched_pkg::ARRIVAL_W'(arrival);
      w.burst       = fsched_pkg::BURST_W'(burst);
      w.last        = last;
      w.drain_first = drain_first;
      pending_words.push_back(w);
   endtask

   task automatic add_set(int n, set_style_type style, bit drain_first);
      int a, b;
      for (int k = 0; k < n; k++) begin
         case (style)
            SET_WIDE: begin
               a = $urandom_range(0, 65535);
               b = $urandom_range(0, 65535);
            end
            SET_DENSE: begin
               a = $urandom_range(0, 60);
               b = $urandom_range(0, 25);
            end
            SET_TIES: begin
               a = $urandom_range(0, 3) * 'h1000;
               b = $urandom_range(0, 3000);
            end
            default: begin
               a = 65535;
               b = 65535;
            end
         endcase
         add_job(a, b, k == n - 1, drain_first && k == 0);
      end
   endtask

   // request driver: bursts of words with random gaps, optional drain hold
   always @(posedge clock) begin
      logic         next_valid;
      job_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            w = pending_words.pop_front();
            // jobs past a full set are dropped, their tlast still closes it
            if (held_jobs.size() < MAX_JOBS)
               held_jobs.push_back('{arrival: w.arrival, burst: w.burst,
                                     id: fsched_pkg::ID_W'(held_jobs.size() + 1)});
            if (w.last)
               schedule_jobs();
            next_valid = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0 &&
                         (!pending_words[0].drain_first ||
                          rows_predicted == rows_checked)) begin
               req_tdata  <= {pending_words[0].burst, pending_words[0].arrival};
               req_tlast  <= pending_words[0].last;
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // receiver backpressure, in modes picked at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_timer == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_timer = $urandom_range(20, 80);
         end else begin
            rx_timer--;
         end
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // response monitor: compare each accepted word against the oldest row
   always @(posedge clock) begin
      timing_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $error("response word with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_rows.pop_front();
            check_field("process_id", want.id, rsp_tdata[0 +: fsched_pkg::ID_W]);
            check_field("arrival_out", want.arrival,
                        rsp_tdata[ARR_LSB +: fsched_pkg::ARR_O_W]);
            check_field("burst_out", want.burst,
                        rsp_tdata[BUR_LSB +: fsched_pkg::BUR_O_W]);
            check_field("completion_time", want.completion,
                        rsp_tdata[COMPL_LSB +: fsched_pkg::COMPL_W]);
            check_field("turnaround_time", want.turnaround,
                        rsp_tdata[TURN_LSB +: fsched_pkg::TURN_W]);
            check_field("waiting_time", want.waiting,
                        rsp_tdata[WAIT_LSB +: fsched_pkg::WAIT_W]);
            check_field("total_turnaround", want.total_turn,
                        rsp_tdata[TTURN_LSB +: fsched_pkg::TTURN_W]);
            check_field("total_waiting", want.total_wait,
                        rsp_tdata[TWAIT_LSB +: fsched_pkg::TWAIT_W]);
            check_field("job_count", want.count,
                        rsp_tdata[COUNT_LSB +: fsched_pkg::COUNT_W]);
            check_field("last_result", want.last, rsp_tlast);
            rows_checked <= rows_checked + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      // single job sets at both extremes
      add_job(0, 0, 1'b1, 1'b0);
      add_job(65535, 65535, 1'b1, 1'b0);
      // reverse arrival order forces a full sort
      add_job(30, 5, 1'b0, 1'b0);
      add_job(20, 7, 1'b0, 1'b0);
      add_job(10, 1, 1'b0, 1'b0);
      add_job(0, 9, 1'b1, 1'b0);
      // equal arrivals must keep load order
      add_job(7, 4, 1'b0, 1'b0);
      add_job(3, 2, 1'b0, 1'b0);
      add_job(7, 0, 1'b0, 1'b0);
      add_job(3, 6, 1'b1, 1'b0);
      // processor goes idle, then jobs queue behind a busy one
      add_job(0, 2, 1'b0, 1'b0);
      add_job(100, 3, 1'b0, 1'b0);
      add_job(101, 0, 1'b1, 1'b0);
      // alternating bit patterns
      add_job('hAAAA, 'h5555, 1'b0, 1'b0);
      add_job('h5555, 'hAAAA, 1'b1, 1'b0);

      // overflowing set at the largest times, closed by a dropped word
      add_set(MAX_JOBS + 2, SET_PEAK, 1'b1);
      add_set(MAX_JOBS, SET_WIDE, 1'b0);
      while (pending_words.size() < TARGET_WORDS)
         add_set($urandom_range(1, 10), set_style_type'($urandom_range(0, 2)),
                 $urandom_range(0, 3) == 0);

      while (pending_words.size() > 0 || rows_predicted != rows_checked)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/fsched_pkg.sv
rtl/fcfs_schedule_times.sv
dv/testbench.sv
